// ===== design/otsu_pkg.sv =====
// shared types and constants of the otsu threshold binarizer
package otsu_pkg;

    localparam int LEVELS     = 256;
    localparam int LEVEL_W    = 8;
    localparam int CNT_W      = 21;
    localparam int SUM_W      = 28;
    localparam int PROD_W     = 49;
    localparam int DEN_W      = 42;
    localparam int SQ_W       = 98;
    localparam int LIMB_W     = 32;
    localparam int MUL_A_W    = 128;
    localparam int MUL_B_W    = 64;
    localparam int MUL_R_W    = 192;

    localparam logic [CNT_W-1:0]   MAX_PIXELS = CNT_W'(1048576);
    localparam logic [LEVEL_W-1:0] LEVEL_MAX  = LEVEL_W'(LEVELS - 1);
    localparam logic [7:0]         WHITE      = 8'd255;
    localparam logic [7:0]         BLACK      = 8'd0;

    localparam logic OP_ACC       = 1'b0;
    localparam logic OP_BIN       = 1'b1;
    localparam logic KIND_THRESH  = 1'b0;
    localparam logic KIND_PIXEL   = 1'b1;

    typedef struct packed {
        logic       opcode;
        logic [7:0] pixel;
        logic       frame_end;
    } in_item_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] value;
    } out_item_t;

    typedef enum logic [1:0] {
        CMD_ACC     = 2'd0,
        CMD_ACC_END = 2'd1,
        CMD_BIN     = 2'd2
    } cmd_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] pixel;
    } q_entry_t;

    typedef struct packed {
        logic     valid;
        q_entry_t entry;
    } q_head_t;

    typedef struct packed {
        logic               start;
        logic [MUL_A_W-1:0] a;
        logic [1:0]         a_top;
        logic [MUL_B_W-1:0] b;
        logic               b_top;
    } mul_req_t;

    typedef struct packed {
        logic               done;
        logic [MUL_R_W-1:0] res;
    } mul_rsp_t;

endpackage

// ===== design/otsu_front.sv =====
// front end: accepts items, classifies them and queues commands
module otsu_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  otsu_pkg::in_item_t s_data,
    output otsu_pkg::q_head_t head,
    input  logic              pop
);

    otsu_pkg::q_entry_t fifo_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    otsu_pkg::q_entry_t entry;

    assign s_ready = (cnt_reg != 2'd2);
    assign push    = s_valid && s_ready;

    always_comb begin
        entry.pixel = s_data.pixel;
        if (s_data.opcode == otsu_pkg::OP_BIN) begin
            entry.cmd = otsu_pkg::CMD_BIN;
        end else if (s_data.frame_end) begin
            entry.cmd = otsu_pkg::CMD_ACC_END;
        end else begin
            entry.cmd = otsu_pkg::CMD_ACC;
        end
    end

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    assign head.valid = (cnt_reg != 2'd0);
    assign head.entry = fifo_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= entry;
        end
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ===== design/otsu_mul.sv =====
// multi-limb multiplier built on one 32x32 product per cycle
module otsu_mul (
    input  logic               aclk,
    input  logic               aresetn,
    input  otsu_pkg::mul_req_t req,
    output otsu_pkg::mul_rsp_t rsp
);

    logic [otsu_pkg::MUL_A_W-1:0] a_reg, a_next;
    logic [otsu_pkg::MUL_B_W-1:0] b_reg, b_next;
    logic [1:0]  a_top_reg, a_top_next;
    logic        b_top_reg, b_top_next;
    logic [1:0]  i_reg, i_next;
    logic        j_reg, j_next;
    logic        busy_reg, busy_next;
    logic        pv_reg, pv_next;
    logic        done_reg, done_next;
    logic [2*otsu_pkg::LIMB_W-1:0] prod_reg, prod_next;
    logic [2:0]  sh_reg, sh_next;
    logic [otsu_pkg::MUL_R_W-1:0] acc_reg, acc_next;
    logic [otsu_pkg::LIMB_W-1:0]  a_limb, b_limb;

    assign a_limb = a_reg[otsu_pkg::LIMB_W*i_reg +: otsu_pkg::LIMB_W];
    assign b_limb = b_reg[otsu_pkg::LIMB_W*j_reg +: otsu_pkg::LIMB_W];

    always_comb begin
        a_next     = a_reg;
        b_next     = b_reg;
        a_top_next = a_top_reg;
        b_top_next = b_top_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        busy_next  = busy_reg;
        pv_next    = busy_reg;
        prod_next  = a_limb * b_limb;
        sh_next    = 3'(i_reg) + 3'(j_reg);
        done_next  = pv_reg && !busy_reg;
        acc_next   = acc_reg;
        if (pv_reg) begin
            acc_next = acc_reg + (otsu_pkg::MUL_R_W'(prod_reg) << (otsu_pkg::LIMB_W * sh_reg));
        end
        if (busy_reg) begin
            if (i_reg == a_top_reg) begin
                i_next = 2'd0;
                if (j_reg == b_top_reg) begin
                    busy_next = 1'b0;
                end else begin
                    j_next = 1'b1;
                end
            end else begin
                i_next = i_reg + 2'd1;
            end
        end
        if (req.start) begin
            a_next     = req.a;
            b_next     = req.b;
            a_top_next = req.a_top;
            b_top_next = req.b_top;
            i_next     = 2'd0;
            j_next     = 1'b0;
            busy_next  = 1'b1;
            pv_next    = 1'b0;
            done_next  = 1'b0;
            acc_next   = '0;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.res  = acc_reg;

    always_ff @(posedge aclk) begin
        a_reg     <= a_next;
        b_reg     <= b_next;
        a_top_reg <= a_top_next;
        b_top_reg <= b_top_next;
        i_reg     <= i_next;
        j_reg     <= j_next;
        prod_reg  <= prod_next;
        sh_reg    <= sh_next;
        acc_reg   <= acc_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            pv_reg   <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            pv_reg   <= pv_next;
            done_reg <= done_next;
        end
    end

endmodule

// ===== design/otsu_back.sv =====
// back end: histogram memory, threshold search sequencer and result register
module otsu_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  otsu_pkg::q_head_t  head,
    output logic               pop,
    output otsu_pkg::mul_req_t mreq,
    input  otsu_pkg::mul_rsp_t mrsp,
    output logic               m_valid,
    input  logic               m_ready,
    output otsu_pkg::out_item_t m_data
);

    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_ACC_WR   = 8'b0000_0010,
        ST_S_RD     = 8'b0000_0100,
        ST_S_UPD    = 8'b0000_1000,
        ST_S_CHK    = 8'b0001_0000,
        ST_MUL_GO   = 8'b0010_0000,
        ST_MUL_WAIT = 8'b0100_0000,
        ST_S_OUT    = 8'b1000_0000
    } state_t;

    typedef enum logic [2:0] {
        J_P   = 3'd0,
        J_Q   = 3'd1,
        J_DEN = 3'd2,
        J_D2  = 3'd3,
        J_LHS = 3'd4,
        J_RHS = 3'd5
    } job_t;

    localparam int LW = otsu_pkg::LEVEL_W;
    localparam int CW = otsu_pkg::CNT_W;
    localparam int SW = otsu_pkg::SUM_W;
    localparam int PW = otsu_pkg::PROD_W;
    localparam int DW = otsu_pkg::DEN_W;
    localparam int QW = otsu_pkg::SQ_W;
    localparam int RW = otsu_pkg::MUL_R_W;
    localparam int AW = otsu_pkg::MUL_A_W;
    localparam int BW = otsu_pkg::MUL_B_W;

    state_t state_reg, state_next;
    job_t   job_reg, job_next;
    logic [LW-1:0] px_reg, px_next;
    logic          fe_reg, fe_next;
    logic [LW-1:0] thr_reg, thr_next;
    logic [CW-1:0] n_reg, n_next;
    logic [SW-1:0] s_reg, s_next;
    logic [LW-1:0] t_reg, t_next;
    logic [CW-1:0] n0_reg, n0_next;
    logic [SW-1:0] s0_reg, s0_next;
    logic [PW-1:0] p_reg, p_next;
    logic [PW-1:0] d_reg, d_next;
    logic [DW-1:0] den_reg, den_next;
    logic [QW-1:0] d2_reg, d2_next;
    logic [RW-1:0] lhs_reg, lhs_next;
    logic [QW-1:0] best_d2_reg, best_d2_next;
    logic [DW-1:0] best_den_reg, best_den_next;
    logic [LW-1:0] best_t_reg, best_t_next;
    logic          out_vld_reg, out_vld_next;
    otsu_pkg::out_item_t out_data_reg, out_data_next;

    logic [CW-1:0] hist_mem [otsu_pkg::LEVELS];
    logic [otsu_pkg::LEVELS-1:0] hvld_reg, hvld_next;
    logic [CW-1:0] rd_data_reg;
    logic          rd_vld_reg;
    logic [LW-1:0] rd_addr;
    logic          wr_en;
    logic [CW-1:0] h, n1;
    logic          out_free;
    logic [PW-1:0] q_val;

    assign h        = rd_vld_reg ? rd_data_reg : '0;
    assign n1       = n_reg - n0_reg;
    assign out_free = !out_vld_reg || m_ready;
    assign q_val    = mrsp.res[PW-1:0];
    assign m_valid  = out_vld_reg;
    assign m_data   = out_data_reg;

    always_comb begin
        mreq.start = (state_reg == ST_MUL_GO);
        mreq.a     = '0;
        mreq.a_top = 2'd0;
        mreq.b     = '0;
        mreq.b_top = 1'b0;
        case (job_reg)
            J_P: begin
                mreq.a = AW'(n_reg);
                mreq.b = BW'(s0_reg);
            end
            J_Q: begin
                mreq.a = AW'(s_reg);
                mreq.b = BW'(n0_reg);
            end
            J_DEN: begin
                mreq.a = AW'(n0_reg);
                mreq.b = BW'(n1);
            end
            J_D2: begin
                mreq.a     = AW'(d_reg);
                mreq.a_top = 2'd1;
                mreq.b     = BW'(d_reg);
                mreq.b_top = 1'b1;
            end
            J_LHS: begin
                mreq.a     = AW'(d2_reg);
                mreq.a_top = 2'd3;
                mreq.b     = BW'(best_den_reg);
                mreq.b_top = 1'b1;
            end
            J_RHS: begin
                mreq.a     = AW'(best_d2_reg);
                mreq.a_top = 2'd3;
                mreq.b     = BW'(den_reg);
                mreq.b_top = 1'b1;
            end
            default: begin
                mreq.a = '0;
            end
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        job_next      = job_reg;
        px_next       = px_reg;
        fe_next       = fe_reg;
        thr_next      = thr_reg;
        n_next        = n_reg;
        s_next        = s_reg;
        t_next        = t_reg;
        n0_next       = n0_reg;
        s0_next       = s0_reg;
        p_next        = p_reg;
        d_next        = d_reg;
        den_next      = den_reg;
        d2_next       = d2_reg;
        lhs_next      = lhs_reg;
        best_d2_next  = best_d2_reg;
        best_den_next = best_den_reg;
        best_t_next   = best_t_reg;
        out_vld_next  = out_vld_reg && !m_ready;
        out_data_next = out_data_reg;
        hvld_next     = hvld_reg;
        pop           = 1'b0;
        wr_en         = 1'b0;
        rd_addr       = head.entry.pixel;
        case (state_reg)
            ST_IDLE: begin
                if (head.valid) begin
                    if (head.entry.cmd == otsu_pkg::CMD_BIN) begin
                        if (out_free) begin
                            pop                 = 1'b1;
                            out_vld_next        = 1'b1;
                            out_data_next.kind  = otsu_pkg::KIND_PIXEL;
                            out_data_next.value = (head.entry.pixel < thr_reg) ?
                                                  otsu_pkg::BLACK : otsu_pkg::WHITE;
                        end
                    end else begin
                        pop        = 1'b1;
                        px_next    = head.entry.pixel;
                        fe_next    = (head.entry.cmd == otsu_pkg::CMD_ACC_END);
                        state_next = ST_ACC_WR;
                    end
                end
            end
            ST_ACC_WR: begin
                if (n_reg < otsu_pkg::MAX_PIXELS) begin
                    wr_en             = 1'b1;
                    hvld_next[px_reg] = 1'b1;
                    n_next            = n_reg + CW'(1);
                    s_next            = s_reg + SW'(px_reg);
                end
                if (fe_reg) begin
                    t_next        = LW'(1);
                    n0_next       = '0;
                    s0_next       = '0;
                    best_d2_next  = '0;
                    best_den_next = DW'(1);
                    best_t_next   = LW'(1);
                    state_next    = ST_S_RD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_S_RD: begin
                rd_addr    = t_reg - LW'(1);
                state_next = ST_S_UPD;
            end
            ST_S_UPD: begin
                n0_next    = n0_reg + h;
                s0_next    = s0_reg + SW'(SW'(h) * SW'(t_reg - LW'(1)));
                state_next = ST_S_CHK;
            end
            ST_S_CHK: begin
                if (n0_reg == '0 || n1 == '0) begin
                    if (t_reg == otsu_pkg::LEVEL_MAX) begin
                        state_next = ST_S_OUT;
                    end else begin
                        t_next     = t_reg + LW'(1);
                        state_next = ST_S_RD;
                    end
                end else begin
                    job_next   = J_P;
                    state_next = ST_MUL_GO;
                end
            end
            ST_MUL_GO: begin
                state_next = ST_MUL_WAIT;
            end
            ST_MUL_WAIT: begin
                if (mrsp.done) begin
                    state_next = ST_MUL_GO;
                    case (job_reg)
                        J_P: begin
                            p_next   = mrsp.res[PW-1:0];
                            job_next = J_Q;
                        end
                        J_Q: begin
                            d_next   = (p_reg > q_val) ? p_reg - q_val : q_val - p_reg;
                            job_next = J_DEN;
                        end
                        J_DEN: begin
                            den_next = mrsp.res[DW-1:0];
                            job_next = J_D2;
                        end
                        J_D2: begin
                            d2_next  = mrsp.res[QW-1:0];
                            job_next = J_LHS;
                        end
                        J_LHS: begin
                            lhs_next = mrsp.res;
                            job_next = J_RHS;
                        end
                        J_RHS: begin
                            if (lhs_reg > mrsp.res) begin
                                best_d2_next  = d2_reg;
                                best_den_next = den_reg;
                                best_t_next   = t_reg;
                            end
                            if (t_reg == otsu_pkg::LEVEL_MAX) begin
                                state_next = ST_S_OUT;
                            end else begin
                                t_next     = t_reg + LW'(1);
                                state_next = ST_S_RD;
                            end
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_S_OUT: begin
                if (out_free) begin
                    out_vld_next        = 1'b1;
                    out_data_next.kind  = otsu_pkg::KIND_THRESH;
                    out_data_next.value = best_t_reg;
                    thr_next            = best_t_reg;
                    n_next              = '0;
                    s_next              = '0;
                    hvld_next           = '0;
                    state_next          = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            hist_mem[px_reg] <= h + CW'(1);
        end
        rd_data_reg <= hist_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        job_reg      <= job_next;
        px_reg       <= px_next;
        fe_reg       <= fe_next;
        t_reg        <= t_next;
        n0_reg       <= n0_next;
        s0_reg       <= s0_next;
        p_reg        <= p_next;
        d_reg        <= d_next;
        den_reg      <= den_next;
        d2_reg       <= d2_next;
        lhs_reg      <= lhs_next;
        best_d2_reg  <= best_d2_next;
        best_den_reg <= best_den_next;
        best_t_reg   <= best_t_next;
        out_data_reg <= out_data_next;
        rd_vld_reg   <= hvld_reg[rd_addr];
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            thr_reg     <= '0;
            n_reg       <= '0;
            s_reg       <= '0;
            out_vld_reg <= 1'b0;
            hvld_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            thr_reg     <= thr_next;
            n_reg       <= n_next;
            s_reg       <= s_next;
            out_vld_reg <= out_vld_next;
            hvld_reg    <= hvld_next;
        end
    end

endmodule

// ===== design/otsu_threshold_binarizer_core.sv =====
// top level of the otsu threshold binarizer
// Accumulate items add a pixel to a 256-bin histogram in the back end (histogram memory
// read, then write); binarize items return 0 below the stored threshold, 255 otherwise.
// A frame-end item then runs the exact Otsu search over split levels 1 to 255, one at a
// time through a shared 32x32 limb multiplier; a level with an empty class skips the
// multiplier. The threshold item is then emitted and the histogram is cleared at once
// by per-bin valid flags. A two-entry command queue lets the input side keep accepting,
// until it is full, while the back end is busy or the result register waits.
module otsu_threshold_binarizer_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  otsu_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output otsu_pkg::out_item_t m_data
);

    otsu_pkg::q_head_t  head;
    logic               pop;
    otsu_pkg::mul_req_t mreq;
    otsu_pkg::mul_rsp_t mrsp;

    otsu_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .head    (head),
        .pop     (pop)
    );

    otsu_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mreq),
        .rsp     (mrsp)
    );

    otsu_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .head    (head),
        .pop     (pop),
        .mreq    (mreq),
        .mrsp    (mrsp),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ===== tb/sv/otsu_threshold_binarizer_core_tb.sv =====
// self-checking testbench of the otsu threshold binarizer with random stimulus and stalls
module otsu_threshold_binarizer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 60000;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    otsu_pkg::in_item_t  s_data;
    logic                m_valid;
    logic                m_ready;
    otsu_pkg::out_item_t m_data;

    otsu_threshold_binarizer_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    otsu_pkg::in_item_t  pending_items[$];
    otsu_pkg::out_item_t expected_results[$];
    int unsigned bin_count[otsu_pkg::LEVELS];
    int unsigned frame_pixels;
    logic [7:0]  level_cut;
    int          fail_count;
    bit          quiet_tail;
    bit          hold_off_req;
    int          watchdog;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // exact otsu search over the predicted histogram
    function automatic logic [7:0] otsu_split();
        longint unsigned n, s, n0, s0, n1, p, q, d, den, best_d, best_den;
        logic [191:0] lhs, rhs;
        int best_t;
        n = 0;
        s = 0;
        n0 = 0;
        s0 = 0;
        best_d = 0;
        best_den = 1;
        best_t = 1;
        for (int t = 0; t < otsu_pkg::LEVELS; t++) begin
            n += bin_count[t];
            s += longint'(bin_count[t]) * t;
        end
        for (int t = 1; t < otsu_pkg::LEVELS; t++) begin
            n0 += bin_count[t-1];
            s0 += longint'(bin_count[t-1]) * (t - 1);
            n1 = n - n0;
            if (n0 != 0 && n1 != 0) begin
                p = n * s0;
                q = s * n0;
                d = (p > q) ? p - q : q - p;
                den = n0 * n1;
                lhs = 192'(d) * 192'(d) * 192'(best_den);
                rhs = 192'(best_d) * 192'(best_d) * 192'(den);
                if (lhs > rhs) begin
                    best_d = d;
                    best_den = den;
                    best_t = t;
                end
            end
        end
        return 8'(best_t);
    endfunction

    task automatic predict_item(input otsu_pkg::in_item_t it);
        otsu_pkg::out_item_t r;
        if (it.opcode == otsu_pkg::OP_BIN) begin
            r.kind = otsu_pkg::KIND_PIXEL;
            r.value = (it.pixel < level_cut) ? otsu_pkg::BLACK : otsu_pkg::WHITE;
            expected_results.push_back(r);
        end else begin
            if (frame_pixels < otsu_pkg::MAX_PIXELS) begin
                bin_count[it.pixel]++;
                frame_pixels++;
            end
            if (it.frame_end) begin
                level_cut = otsu_split();
                for (int i = 0; i < otsu_pkg::LEVELS; i++) bin_count[i] = 0;
                frame_pixels = 0;
                r.kind = otsu_pkg::KIND_THRESH;
                r.value = level_cut;
                expected_results.push_back(r);
            end
        end
    endtask

    function automatic otsu_pkg::in_item_t make_item(logic op, logic [7:0] px, logic fe);
        otsu_pkg::in_item_t it;
        it.opcode = op;
        it.pixel = px;
        it.frame_end = fe;
        return it;
    endfunction

    // frame of pixels drawn around one or two gray levels, then some binarize items
    task automatic add_frame(int npix);
        int c0, c1, spread;
        c0 = $urandom_range(0, 255);
        c1 = $urandom_range(0, 255);
        spread = $urandom_range(0, 40);
        for (int i = 0; i < npix; i++) begin
            int v;
            v = (($urandom % 2) ? c0 : c1) + $urandom_range(0, 2 * spread) - spread;
            if (v < 0) v = 0;
            if (v > 255) v = 255;
            pending_items.push_back(make_item(otsu_pkg::OP_ACC, 8'(v), i == npix - 1));
        end
        repeat ($urandom_range(1, 8))
            pending_items.push_back(make_item(otsu_pkg::OP_BIN, 8'($urandom), 1'($urandom)));
    endtask

    // driver
    int send_gap;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data <= '0;
            send_gap <= 0;
        end else if (!s_valid || s_ready) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_valid <= 1'b0;
            end else if (pending_items.size() > 0 && !(!quiet_tail && $urandom_range(0, 9) == 0)) begin
                s_data <= pending_items.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
                if (!quiet_tail && pending_items.size() > 0) send_gap <= $urandom_range(1, 12);
            end
        end
    end

    // prediction on accepted input items
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) predict_item(s_data);
    end

    // receiver stalls, including one long hold-off
    int stall_left;
    int hold_left;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left <= 0;
            hold_left <= 0;
        end else if (hold_off_req && hold_left == 0 && stall_left >= 0) begin
            hold_left <= 400;
            m_ready <= 1'b0;
            stall_left <= -1;
        end else if (hold_left > 1) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else if (hold_left == 1) begin
            hold_left <= 0;
            stall_left <= 0;
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(1, 12);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // monitor
    always @(posedge aclk) begin
        otsu_pkg::out_item_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result kind=%0d value=%0d", m_data.kind, m_data.value);
                fail_count++;
            end else begin
                exp_r = expected_results.pop_front();
                if (m_data.kind !== exp_r.kind) begin
                    $error("kind expected %0d actual %0d", exp_r.kind, m_data.kind);
                    fail_count++;
                end
                if (m_data.value !== exp_r.value) begin
                    $error("value expected %0d actual %0d", exp_r.value, m_data.value);
                    fail_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            watchdog <= 0;
        end else if (watchdog >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            watchdog <= watchdog + 1;
        end
    end

    initial begin
        fail_count = 0;
        quiet_tail = 0;
        hold_off_req = 0;
        level_cut = 0;
        frame_pixels = 0;
        for (int i = 0; i < otsu_pkg::LEVELS; i++) bin_count[i] = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;

        // binarize before any frame, extremes
        pending_items.push_back(make_item(otsu_pkg::OP_BIN, 8'd0, 1'b0));
        pending_items.push_back(make_item(otsu_pkg::OP_BIN, 8'd255, 1'b1));
        // empty-class frame: single pixel
        pending_items.push_back(make_item(otsu_pkg::OP_ACC, 8'd255, 1'b1));
        pending_items.push_back(make_item(otsu_pkg::OP_BIN, 8'd0, 1'b0));
        // two extreme levels
        pending_items.push_back(make_item(otsu_pkg::OP_ACC, 8'd0, 1'b0));
        pending_items.push_back(make_item(otsu_pkg::OP_ACC, 8'd255, 1'b0));
        pending_items.push_back(make_item(otsu_pkg::OP_ACC, 8'd0, 1'b0));
        pending_items.push_back(make_item(otsu_pkg::OP_ACC, 8'd255, 1'b1));
        pending_items.push_back(make_item(otsu_pkg::OP_BIN, 8'd254, 1'b0));
        pending_items.push_back(make_item(otsu_pkg::OP_BIN, 8'd255, 1'b0));
        pending_items.push_back(make_item(otsu_pkg::OP_BIN, 8'd1, 1'b1));
        // tie between splits
        pending_items.push_back(make_item(otsu_pkg::OP_ACC, 8'd10, 1'b0));
        pending_items.push_back(make_item(otsu_pkg::OP_ACC, 8'd20, 1'b0));
        pending_items.push_back(make_item(otsu_pkg::OP_ACC, 8'd30, 1'b1));
        pending_items.push_back(make_item(otsu_pkg::OP_BIN, 8'd15, 1'b0));
        pending_items.push_back(make_item(otsu_pkg::OP_BIN, 8'd170, 1'b0));

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // random frames
        while (pending_items.size() < 560) add_frame($urandom_range(2, 30));
        // a few noise items
        repeat (20) pending_items.push_back(make_item(1'($urandom), 8'($urandom), 1'b0));
        pending_items.push_back(make_item(otsu_pkg::OP_ACC, 8'($urandom), 1'b1));

        // long receiver hold-off while the sender keeps going
        wait (pending_items.size() < 450);
        @(posedge aclk);
        hold_off_req <= 1'b1;
        @(posedge aclk);
        hold_off_req <= 1'b0;

        wait (pending_items.size() == 0);
        // last part: no idling
        repeat (3) add_frame($urandom_range(2, 20));
        quiet_tail = 1;
        wait (pending_items.size() == 0 && !s_valid);
        wait (expected_results.size() == 0);
        repeat (200) @(posedge aclk);

        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
